>>> rtl/ihex_pkg.sv
package ihex_pkg;

  // parser phase, one per field position of a record
  typedef enum logic [4:0] {
    PH_START,
    PH_LEN0,
    PH_LEN1,
    PH_ADDR0,
    PH_ADDR1,
    PH_ADDR2,
    PH_ADDR3,
    PH_TYPE0,
    PH_TYPE1,
    PH_DATA,
    PH_CK0,
    PH_CK1,
    PH_OFF0,
    PH_OFF1,
    PH_OFF2,
    PH_OFF3,
    PH_DONE
  } phase_t;

  // classified character: either a colon or a hex nibble
  typedef struct packed {
    logic       is_colon;
    logic [3:0] nib;
  } ihex_tok_t;

  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // record type digits
  localparam logic [3:0] REC_DATA = 4'h0;
  localparam logic [3:0] REC_EOF  = 4'h1;
  localparam logic [3:0] REC_SEG  = 4'h2;
  localparam logic [3:0] REC_LIN  = 4'h4;

endpackage

>>> rtl/ihex_front.sv
module ihex_front import ihex_pkg::*; (
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_char,
  input  logic      q_full,
  output logic      q_push,
  output ihex_tok_t q_tok
);

  logic       is_hex;
  logic [3:0] nib;

  always_comb begin
    is_hex = 1'b1;
    nib    = 4'h0;
    if (in_char >= 8'h30 && in_char <= 8'h39) begin
      nib = in_char[3:0];
    end else if ((in_char >= 8'h61 && in_char <= 8'h66) ||
                 (in_char >= 8'h41 && in_char <= 8'h46)) begin
      nib = 4'(in_char[3:0] + 4'd9);
    end else begin
      is_hex = 1'b0;
    end
  end

  // anything that is neither hex nor colon is dropped here
  assign in_ready       = !q_full;
  assign q_push         = in_valid && !q_full && (is_hex || in_char == CHAR_COLON);
  assign q_tok.is_colon = !is_hex;
  assign q_tok.nib      = nib;

endmodule

>>> rtl/ihex_fifo.sv
module ihex_fifo import ihex_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ihex_tok_t push_tok,
  output logic      full,
  input  logic      pop,
  output logic      tok_valid,
  output ihex_tok_t tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ihex_tok_t         mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign tok_valid = (cnt_r != '0);
  assign tok       = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && tok_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

endmodule

>>> rtl/ihex_back.sv
module ihex_back import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] flash_base,
  input  logic        tok_valid,
  input  ihex_tok_t   tok,
  output logic        tok_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [31:0] out_byte_address,
  output logic [7:0]  out_data_byte,
  output logic        out_checksum_ok,
  output logic        out_end_of_file
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [31:0] seg_r, seg_nxt;
  logic        sh16_r, sh16_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [3:0]  chk_r, chk_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [31:0] ptr_r, ptr_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic        pend_r, pend_nxt;
  logic        eof_r, eof_nxt;

  logic        ov_r, ov_nxt;
  logic        okind_r, okind_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [7:0]  odata_r, odata_nxt;
  logic        ook_r, ook_nxt;
  logic        oeof_r, oeof_nxt;

  logic [7:0]  byte_val;
  logic [3:0]  nib;

  assign nib     = tok.nib;
  assign tok_pop = tok_valid && (!ov_r || out_ready);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    addr_nxt  = addr_r;
    seg_nxt   = seg_r;
    sh16_nxt  = sh16_r;
    sum_nxt   = sum_r;
    chk_nxt   = chk_r;
    idx_nxt   = idx_r;
    ptr_nxt   = ptr_r;
    hi_nxt    = hi_r;
    pend_nxt  = pend_r;
    eof_nxt   = eof_r;
    ov_nxt    = ov_r && !out_ready;
    okind_nxt = okind_r;
    oaddr_nxt = oaddr_r;
    odata_nxt = odata_r;
    ook_nxt   = ook_r;
    oeof_nxt  = oeof_r;
    byte_val  = {hi_r, nib};

    if (tok_pop) begin
      case (phase_r)
        PH_START: begin
          if (tok.is_colon) begin
            phase_nxt = PH_LEN0;
          end
        end
        PH_DONE: begin
        end
        default: begin
          if (!tok.is_colon) begin
            case (phase_r)
              PH_LEN0: begin
                len_nxt   = {4'h0, nib};
                phase_nxt = PH_LEN1;
              end
              PH_LEN1: begin
                len_nxt   = {len_r[3:0], nib};
                sum_nxt   = {len_r[3:0], nib};
                phase_nxt = PH_ADDR0;
              end
              PH_ADDR0: begin
                addr_nxt  = {12'h000, nib};
                phase_nxt = PH_ADDR1;
              end
              PH_ADDR1: begin
                addr_nxt  = {addr_r[11:0], nib};
                sum_nxt   = 8'(sum_r + {addr_r[3:0], nib});
                phase_nxt = PH_ADDR2;
              end
              PH_ADDR2: begin
                addr_nxt  = {addr_r[11:0], nib};
                phase_nxt = PH_ADDR3;
              end
              PH_ADDR3: begin
                addr_nxt  = {addr_r[11:0], nib};
                sum_nxt   = 8'(sum_r + {addr_r[3:0], nib});
                phase_nxt = PH_TYPE0;
              end
              PH_TYPE0: begin
                if (nib == 4'h0) begin
                  phase_nxt = PH_TYPE1;
                end
              end
              PH_TYPE1: begin
                case (nib)
                  REC_DATA: begin
                    idx_nxt   = 8'h00;
                    pend_nxt  = 1'b0;
                    ptr_nxt   = 32'(seg_r + {16'h0000, addr_r});
                    phase_nxt = (len_r == 8'h00) ? PH_CK0 : PH_DATA;
                  end
                  REC_EOF: begin
                    eof_nxt   = 1'b1;
                    sum_nxt   = 8'(sum_r + 8'h01);
                    phase_nxt = PH_CK0;
                  end
                  REC_SEG, REC_LIN: begin
                    seg_nxt   = 32'h0;
                    sh16_nxt  = (nib == REC_LIN);
                    sum_nxt   = 8'(sum_r + {4'h0, nib});
                    phase_nxt = PH_OFF0;
                  end
                  default: begin
                  end
                endcase
              end
              PH_OFF0: begin
                seg_nxt   = {28'h0, nib};
                phase_nxt = PH_OFF1;
              end
              PH_OFF1: begin
                seg_nxt   = {16'h0000, seg_r[11:0], nib};
                sum_nxt   = 8'(sum_r + {seg_r[3:0], nib});
                phase_nxt = PH_OFF2;
              end
              PH_OFF2: begin
                seg_nxt   = {16'h0000, seg_r[11:0], nib};
                phase_nxt = PH_OFF3;
              end
              PH_OFF3: begin
                sum_nxt   = 8'(sum_r + {seg_r[3:0], nib});
                seg_nxt   = sh16_r ? {seg_r[11:0], nib, 16'h0000}
                                   : {12'h000, seg_r[11:0], nib, 4'h0};
                phase_nxt = PH_CK0;
              end
              PH_DATA: begin
                if (!pend_r) begin
                  hi_nxt   = nib;
                  pend_nxt = 1'b1;
                end else begin
                  pend_nxt  = 1'b0;
                  sum_nxt   = 8'(sum_r + byte_val);
                  idx_nxt   = 8'(idx_r + 8'd1);
                  ptr_nxt   = 32'(ptr_r + 32'd1);
                  if (8'(idx_r + 8'd1) == len_r) begin
                    phase_nxt = PH_CK0;
                  end
                  ov_nxt    = 1'b1;
                  okind_nxt = 1'b0;
                  oaddr_nxt = 32'(flash_base + ptr_r);
                  odata_nxt = byte_val;
                  ook_nxt   = 1'b0;
                  oeof_nxt  = 1'b0;
                end
              end
              PH_CK0: begin
                chk_nxt   = nib;
                phase_nxt = PH_CK1;
              end
              PH_CK1: begin
                ov_nxt    = 1'b1;
                okind_nxt = 1'b1;
                oaddr_nxt = 32'h0;
                odata_nxt = 8'h00;
                ook_nxt   = (8'(sum_r + {chk_r, nib}) == 8'h00);
                oeof_nxt  = eof_r;
                sum_nxt   = 8'h00;
                phase_nxt = eof_r ? PH_DONE : PH_START;
              end
              default: begin
                phase_nxt = PH_START;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      seg_r   <= 32'h0;
      pend_r  <= 1'b0;
      eof_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      seg_r   <= seg_nxt;
      pend_r  <= pend_nxt;
      eof_r   <= eof_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    addr_r  <= addr_nxt;
    sh16_r  <= sh16_nxt;
    sum_r   <= sum_nxt;
    chk_r   <= chk_nxt;
    idx_r   <= idx_nxt;
    ptr_r   <= ptr_nxt;
    hi_r    <= hi_nxt;
    okind_r <= okind_nxt;
    oaddr_r <= oaddr_nxt;
    odata_r <= odata_nxt;
    ook_r   <= ook_nxt;
    oeof_r  <= oeof_nxt;
  end

  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_byte_address = oaddr_r;
  assign out_data_byte    = odata_r;
  assign out_checksum_ok  = ook_r;
  assign out_end_of_file  = oeof_r;

  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && okind_r |-> oaddr_r == 32'h0 && odata_r == 8'h00)
    else $error("record finished carries address or data");

  a_data_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !okind_r |-> !ook_r && !oeof_r)
    else $error("data byte carries record flags");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("left end state without reset");

  a_pend_data: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> phase_r == PH_DATA)
    else $error("half byte pending outside data field");

  a_eof_tail: assert property (@(posedge clk) disable iff (!rst_n)
    eof_r |-> phase_r == PH_CK0 || phase_r == PH_CK1 || phase_r == PH_DONE)
    else $error("end record seen but parser not in checksum or end");

endmodule

>>> rtl/intel_hex_record_parser_top.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_char_in
// out     | output    | out_valid / out_ready | out_kind, out_byte_address, out_data_byte,
//         |           |                       | out_checksum_ok, out_end_of_file
// cfg     | input     | cfg_wr_en             | cfg_wr_data (flash base)
//
// one character per cycle sustained while the queue is not full; a character's result
// reaches the result register through the queue write, then the parser step
// the character queue of QUEUE_DEPTH entries lets the input keep flowing while a
// result waits on out_ready; in_ready drops only when the queue is full
// rst_n is synchronous, active low; it clears the parser, the offset and the base
// after the end record every character is taken and dropped until reset
module intel_hex_record_parser_top import ihex_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [31:0] out_byte_address,
  output logic [7:0]  out_data_byte,
  output logic        out_checksum_ok,
  output logic        out_end_of_file,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  // flash base register; the user must write it only while the parser is quiet, the block does not enforce it
  logic [31:0] flash_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_base_r <= 32'h0;
    end else if (cfg_wr_en) begin
      flash_base_r <= cfg_wr_data;
    end
  end

  // front to queue
  logic      q_push;
  logic      q_full;
  ihex_tok_t q_tok;

  // queue to parser
  logic      tok_valid;
  logic      tok_pop;
  ihex_tok_t tok;

  // front: classify each character, keep only colons and hex digits
  ihex_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_char  (in_char_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_tok    (q_tok)
  );

  // short queue decoupling the front from the parser
  ihex_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (q_tok),
    .full      (q_full),
    .pop       (tok_pop),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  // back: record state machine, checksum, address pointer and result register
  ihex_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .flash_base       (flash_base_r),
    .tok_valid        (tok_valid),
    .tok              (tok),
    .tok_pop          (tok_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte_address (out_byte_address),
    .out_data_byte    (out_data_byte),
    .out_checksum_ok  (out_checksum_ok),
    .out_end_of_file  (out_end_of_file)
  );

endmodule
